### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fcs_pkg.sv
// Types, constants and helper functions of the flash command sequencer.
package fcs_pkg;

    localparam int ADDR_W      = 21;
    localparam int COUNT_W     = 22;
    localparam int DATA_W      = 16;
    localparam int BLOCK_W     = 7;

    localparam logic [BLOCK_W-1:0] NUM_BLOCKS  = 7'd71;
    localparam logic [COUNT_W-1:0] FLASH_WORDS = 22'd2097152;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [DATA_W-1:0] CMD_LOCK_SETUP = 16'h0060;
    localparam logic [DATA_W-1:0] CMD_CONFIRM    = 16'h00D0;
    localparam logic [DATA_W-1:0] CMD_READ_ID    = 16'h0090;
    localparam logic [DATA_W-1:0] CMD_READ_ARRAY = 16'h00FF;
    localparam logic [DATA_W-1:0] CMD_CLR_STATUS = 16'h0050;
    localparam logic [DATA_W-1:0] CMD_ERASE      = 16'h0020;
    localparam logic [DATA_W-1:0] CMD_PROGRAM    = 16'h0040;
    localparam logic [DATA_W-1:0] SR_READY       = 16'h0080;
    localparam logic [DATA_W-1:0] SR_ERASE_ERR   = 16'h002A;
    localparam logic [DATA_W-1:0] SR_PROG_ERR    = 16'h001A;
    localparam logic [DATA_W-1:0] PROT_LOCKED    = 16'h0001;
    localparam logic [ADDR_W-1:0] PROT_OFFSET    = 21'd2;

    typedef enum logic [1:0] {
        OP_UNLOCK  = 2'd0,
        OP_ERASE   = 2'd1,
        OP_PROGRAM = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_UNLOCK  = 2'd1,
        PEND_ERASE   = 2'd2,
        PEND_PROGRAM = 2'd3
    } pend_t;

    typedef enum logic [2:0] {
        SEQ_REJECT,
        SEQ_DONE_OK,
        SEQ_FINISH,
        SEQ_FAIL_CLR,
        SEQ_REPOLL,
        SEQ_UNLOCK,
        SEQ_ERASE,
        SEQ_PROGRAM
    } seq_kind_t;

    typedef struct packed {
        seq_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic                fail;
    } seq_entry_t;

    typedef struct packed {
        logic                access_valid;
        logic                access_write;
        logic [ADDR_W-1:0]   access_address;
        logic [DATA_W-1:0]   access_data;
        logic                done_res;
        logic                failed;
        logic                last;
    } result_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

    function automatic logic [ADDR_W-1:0] block_offset(input logic [BLOCK_W-1:0] blk);
        logic [BLOCK_W-1:0] diff;
        diff = blk - 7'd7;
        if (blk < 7'd8) begin
            block_offset = {6'd0, blk[2:0], 12'd0};
        end else begin
            block_offset = {diff[5:0], 15'd0};
        end
    endfunction

endpackage

### rtl/core/fcs_front.sv
// Front end: accepts requests, tracks the flash state and classifies each request.
module fcs_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [1:0]                operation,
    input  logic [6:0]                block_number,
    input  logic [20:0]               word_address,
    input  logic [21:0]               run_words,
    input  logic [15:0]               write_data,
    input  logic [15:0]               read_data,
    output fcs_pkg::seq_entry_t       entry
);
    import fcs_pkg::*;

    pend_t               pending_reg, pending_next;
    logic [ADDR_W-1:0]   poll_reg, poll_next;
    logic [COUNT_W-1:0]  remain_reg, remain_next;
    logic [ADDR_W-1:0]   next_addr_reg, next_addr_next;
    logic                aborted_reg, aborted_next;

    logic [ADDR_W-1:0]   offset;
    logic [COUNT_W-1:0]  remain_dec;
    logic [COUNT_W-1:0]  room;
    logic                bad_range;
    logic [ADDR_W-1:0]   prog_addr;
    op_t                 op;

    always_comb begin
        op         = op_t'(operation);
        offset     = block_offset(block_number);
        remain_dec = (remain_reg != '0) ? remain_reg - 22'd1 : '0;
        room       = FLASH_WORDS - {1'b0, word_address};
        bad_range  = ({1'b0, word_address} >= FLASH_WORDS) || (run_words > room);
        prog_addr  = next_addr_reg;

        pending_next   = pending_reg;
        poll_next      = poll_reg;
        remain_next    = remain_reg;
        next_addr_next = next_addr_reg;
        aborted_next   = aborted_reg;

        entry.kind = SEQ_REJECT;
        entry.addr = '0;
        entry.data = '0;
        entry.fail = 1'b0;

        if (op == OP_STATUS) begin
            case (pending_reg)
                PEND_NONE: begin
                    entry.kind = SEQ_REJECT;
                end
                PEND_UNLOCK: begin
                    pending_next = PEND_NONE;
                    entry.kind   = SEQ_FINISH;
                    entry.fail   = (read_data & PROT_LOCKED) != '0;
                end
                default: begin
                    if ((read_data & SR_READY) == '0) begin
                        entry.kind = SEQ_REPOLL;
                        entry.addr = poll_reg;
                    end else if (pending_reg == PEND_ERASE) begin
                        pending_next = PEND_NONE;
                        entry.kind   = ((read_data & SR_ERASE_ERR) != '0) ?
                                       SEQ_FAIL_CLR : SEQ_FINISH;
                    end else begin
                        pending_next = PEND_NONE;
                        remain_next  = remain_dec;
                        if ((read_data & SR_PROG_ERR) != '0) begin
                            aborted_next = remain_dec != '0;
                            entry.kind   = SEQ_FAIL_CLR;
                        end else if (remain_dec == '0) begin
                            entry.kind = SEQ_FINISH;
                        end else begin
                            entry.kind = SEQ_DONE_OK;
                        end
                    end
                end
            endcase
        end else if (pending_reg != PEND_NONE) begin
            entry.kind = SEQ_REJECT;
        end else if (op == OP_PROGRAM) begin
            if (remain_reg != '0 && aborted_reg) begin
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    aborted_next = 1'b0;
                end
                entry.kind = SEQ_REJECT;
            end else if (remain_reg == '0 && bad_range) begin
                entry.kind = SEQ_REJECT;
            end else if (remain_reg == '0 && run_words == '0) begin
                entry.kind = SEQ_FINISH;
            end else begin
                if (remain_reg == '0) begin
                    remain_next  = run_words;
                    aborted_next = 1'b0;
                    prog_addr    = word_address;
                end
                entry.kind     = SEQ_PROGRAM;
                entry.addr     = prog_addr;
                entry.data     = write_data;
                poll_next      = prog_addr;
                next_addr_next = prog_addr + 21'd1;
                pending_next   = PEND_PROGRAM;
            end
        end else if (remain_reg != '0 || block_number >= NUM_BLOCKS) begin
            entry.kind = SEQ_REJECT;
        end else if (op == OP_UNLOCK) begin
            entry.kind   = SEQ_UNLOCK;
            entry.addr   = offset;
            poll_next    = offset + PROT_OFFSET;
            pending_next = PEND_UNLOCK;
        end else begin
            entry.kind   = SEQ_ERASE;
            entry.addr   = offset;
            poll_next    = '0;
            pending_next = PEND_ERASE;
        end

        if (entry.kind == SEQ_REJECT) begin
            entry.fail = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= PEND_NONE;
            poll_reg      <= '0;
            remain_reg    <= '0;
            next_addr_reg <= '0;
            aborted_reg   <= 1'b0;
        end else if (accept) begin
            pending_reg   <= pending_next;
            poll_reg      <= poll_next;
            remain_reg    <= remain_next;
            next_addr_reg <= next_addr_next;
            aborted_reg   <= aborted_next;
        end
    end

endmodule

### rtl/core/fcs_queue.sv
// Short queue of classified requests between the front end and the back end.
module fcs_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  fcs_pkg::seq_entry_t      push_entry,
    input  logic                     pop,
    output fcs_pkg::seq_entry_t      head_entry,
    output fcs_pkg::queue_status_t   status
);
    import fcs_pkg::*;

    seq_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    always_comb begin
        status.full       = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
        status.head_valid = count_reg != '0;
        head_entry        = slot_reg[rd_ptr_reg];
        wr_ptr_next       = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next       = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next        = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/fcs_back.sv
// Back end: expands each classified request into bus accesses and reports.
module fcs_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fcs_pkg::seq_entry_t      head_entry,
    input  logic                     head_valid,
    output logic                     pop,
    output fcs_pkg::result_t         result,
    output logic                     result_valid,
    input  logic                     result_ready
);
    import fcs_pkg::*;

    logic [1:0]  step_reg, step_next;
    logic        valid_reg, valid_next;
    result_t     res_reg;
    result_t     cur;
    logic        load;

    always_comb begin
        cur = '0;
        case (head_entry.kind)
            SEQ_REJECT: begin
                cur.done_res = 1'b1;
                cur.failed   = 1'b1;
                cur.last     = 1'b1;
            end
            SEQ_DONE_OK: begin
                cur.done_res = 1'b1;
                cur.last     = 1'b1;
            end
            SEQ_FINISH: begin
                cur.access_valid = 1'b1;
                cur.access_write = 1'b1;
                cur.access_data  = CMD_READ_ARRAY;
                cur.done_res     = 1'b1;
                cur.failed       = head_entry.fail;
                cur.last         = 1'b1;
            end
            SEQ_FAIL_CLR: begin
                cur.access_valid = 1'b1;
                cur.access_write = 1'b1;
                if (step_reg == 2'd0) begin
                    cur.access_data = CMD_CLR_STATUS;
                end else begin
                    cur.access_data = CMD_READ_ARRAY;
                    cur.done_res    = 1'b1;
                    cur.failed      = 1'b1;
                    cur.last        = 1'b1;
                end
            end
            SEQ_REPOLL: begin
                cur.access_valid   = 1'b1;
                cur.access_address = head_entry.addr;
                cur.last           = 1'b1;
            end
            default: begin
                cur.access_valid = 1'b1;
                cur.access_write = 1'b1;
                case (step_reg)
                    2'd0: begin
                        cur.access_data = (head_entry.kind == SEQ_UNLOCK) ?
                                          CMD_LOCK_SETUP : CMD_CLR_STATUS;
                    end
                    2'd1: begin
                        if (head_entry.kind == SEQ_UNLOCK) begin
                            cur.access_address = head_entry.addr;
                            cur.access_data    = CMD_CONFIRM;
                        end else begin
                            cur.access_data = (head_entry.kind == SEQ_ERASE) ?
                                              CMD_ERASE : CMD_PROGRAM;
                        end
                    end
                    2'd2: begin
                        if (head_entry.kind == SEQ_UNLOCK) begin
                            cur.access_data = CMD_READ_ID;
                        end else if (head_entry.kind == SEQ_ERASE) begin
                            cur.access_address = head_entry.addr;
                            cur.access_data    = CMD_CONFIRM;
                        end else begin
                            cur.access_address = head_entry.addr;
                            cur.access_data    = head_entry.data;
                        end
                    end
                    default: begin
                        cur.access_write = 1'b0;
                        cur.last         = 1'b1;
                        if (head_entry.kind == SEQ_UNLOCK) begin
                            cur.access_address = head_entry.addr + PROT_OFFSET;
                        end else if (head_entry.kind == SEQ_PROGRAM) begin
                            cur.access_address = head_entry.addr;
                        end
                    end
                endcase
            end
        endcase

        load       = head_valid && (!valid_reg || result_ready);
        pop        = load && cur.last;
        step_next  = load ? (cur.last ? 2'd0 : step_reg + 2'd1) : step_reg;
        valid_next = load || (valid_reg && !result_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= cur;
        end
    end

    assign result       = res_reg;
    assign result_valid = valid_reg;

endmodule

### rtl/core/flash_command_sequencer.sv
// Top level of the flash command sequencer: front end, request queue and back end.
//
//  Channel   Direction  Handshake            Content
//  s_        in         s_valid / s_ready    one request: operation and its operands
//  m_        out        m_valid / m_ready    one bus access and/or completion report
//
// A request is accepted whenever the four-entry queue has room, one per cycle.
// The back end issues one result per cycle unless m_ready stalls it, and a request yields
// one to four results; a request passes through a queue slot, then the output register.
// Reset is synchronous and active low and clears the flash state and the queue.
// A stall on m_ready fills the queue, and s_ready drops only when it is full.
module flash_command_sequencer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_operation,
    input  logic [6:0]   s_block_number,
    input  logic [20:0]  s_word_address,
    input  logic [21:0]  s_run_words,
    input  logic [15:0]  s_write_data,
    input  logic [15:0]  s_read_data,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_access_valid,
    output logic         m_access_write,
    output logic [20:0]  m_access_address,
    output logic [15:0]  m_access_data,
    output logic         m_done_res,
    output logic         m_failed,
    output logic         m_last
);
    import fcs_pkg::*;

    seq_entry_t     front_entry;
    seq_entry_t     head_entry;
    queue_status_t  q_status;
    logic           accept;
    logic           pop;
    result_t        result;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    fcs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .operation    (s_operation),
        .block_number (s_block_number),
        .word_address (s_word_address),
        .run_words    (s_run_words),
        .write_data   (s_write_data),
        .read_data    (s_read_data),
        .entry        (front_entry)
    );

    fcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_entry (front_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    fcs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_entry   (head_entry),
        .head_valid   (q_status.head_valid),
        .pop          (pop),
        .result       (result),
        .result_valid (m_valid),
        .result_ready (m_ready)
    );

    assign m_access_valid   = result.access_valid;
    assign m_access_write   = result.access_write;
    assign m_access_address = result.access_address;
    assign m_access_data    = result.access_data;
    assign m_done_res       = result.done_res;
    assign m_failed         = result.failed;
    assign m_last           = result.last;

endmodule

### rtl/core/fcs_checker.sv
// Port-level checker for the flash command sequencer and its bind statement.
`include "assert_macros.svh"

module fcs_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic         m_access_valid,
    input  logic         m_access_write,
    input  logic [20:0]  m_access_address,
    input  logic [15:0]  m_access_data,
    input  logic         m_done_res,
    input  logic         m_failed,
    input  logic         m_last
);

    `ASSERT_SAME(a_no_access_clean, m_valid && !m_access_valid,
        !m_access_write && m_access_address == 21'd0 && m_access_data == 16'd0,
        "report without access carries bus fields")
    `ASSERT_SAME(a_read_no_data, m_valid && m_access_valid && !m_access_write,
        m_access_data == 16'd0, "read access carries data")
    `ASSERT_SAME(a_done_is_last, m_valid && (m_done_res || m_failed), m_done_res && m_last,
        "completion report is not the last result of its request")
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_access_address) && $stable(m_access_data) && $stable(m_last),
        "stalled result changed")

endmodule

bind flash_command_sequencer fcs_checker u_fcs_checker (.*);

### bench/flash_command_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench: directed requests, then random flash sessions.
module flash_command_sequencer_test;

    import fcs_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned FLASH_SIZE   = 2097152;

    typedef struct packed {
        op_t         op;
        logic [6:0]  blk;
        logic [20:0] waddr;
        logic [21:0] rwords;
        logic [15:0] wdata;
        logic [15:0] rdata;
    } request_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  exp;
    } table_row_t;

    localparam result_t EXP_REJECT = '{access_valid: 1'b0, access_write: 1'b0,
        access_address: '0, access_data: '0, done_res: 1'b1, failed: 1'b1, last: 1'b1};
    localparam result_t EXP_FINISH_OK = '{access_valid: 1'b1, access_write: 1'b1,
        access_address: '0, access_data: CMD_READ_ARRAY, done_res: 1'b1, failed: 1'b0,
        last: 1'b1};
    localparam result_t EXP_FINISH_FAIL = '{access_valid: 1'b1, access_write: 1'b1,
        access_address: '0, access_data: CMD_READ_ARRAY, done_res: 1'b1, failed: 1'b1,
        last: 1'b1};
    localparam result_t EXP_REPOLL_BASE = '{access_valid: 1'b1, access_write: 1'b0,
        access_address: '0, access_data: '0, done_res: 1'b0, failed: 1'b0, last: 1'b1};
    localparam result_t EXP_WORD_OK = '{access_valid: 1'b0, access_write: 1'b0,
        access_address: '0, access_data: '0, done_res: 1'b1, failed: 1'b0, last: 1'b1};
    localparam result_t EXP_NONE = '0;

    localparam table_row_t DIRECTED [25] = '{
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_UNLOCK,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_ERASE,   7'd3,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1,
            EXP_FINISH_OK},
        '{'{OP_UNLOCK,  7'd70,  21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0001}, 1'b1,
            EXP_FINISH_FAIL},
        '{'{OP_UNLOCK,  7'd71,  21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_ERASE,   7'd127, 21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_ERASE,   7'd8,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h007F}, 1'b1,
            EXP_REPOLL_BASE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0080}, 1'b1,
            EXP_FINISH_OK},
        '{'{OP_ERASE,   7'd7,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'hFFFF}, 1'b0, EXP_NONE},
        '{'{OP_PROGRAM, 7'd0,   21'h1FFFFF,   22'd1,        16'hFFFF, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0080}, 1'b1,
            EXP_FINISH_OK},
        '{'{OP_PROGRAM, 7'd0,   21'd0,        22'd0,        16'h1234, 16'h0000}, 1'b1,
            EXP_FINISH_OK},
        '{'{OP_PROGRAM, 7'd0,   21'h1FFFFD,   22'd4,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_PROGRAM, 7'd0,   21'd0,        22'h3FFFFF,   16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_PROGRAM, 7'd0,   21'h1FFFFD,   22'd3,        16'h0000, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0080}, 1'b1,
            EXP_WORD_OK},
        '{'{OP_ERASE,   7'd0,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_PROGRAM, 7'd0,   21'h155555,   22'h2AAAAA,   16'hAAAA, 16'h0000}, 1'b0, EXP_NONE},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0090}, 1'b0, EXP_NONE},
        '{'{OP_PROGRAM, 7'd0,   21'd0,        22'd0,        16'h5555, 16'h0000}, 1'b1, EXP_REJECT},
        '{'{OP_STATUS,  7'd0,   21'd0,        22'd0,        16'h0000, 16'h0000}, 1'b1, EXP_REJECT}
    };

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation      = '0;
    logic [6:0]  s_block_number   = '0;
    logic [20:0] s_word_address   = '0;
    logic [21:0] s_run_words      = '0;
    logic [15:0] s_write_data     = '0;
    logic [15:0] s_read_data      = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_access_valid;
    logic        m_access_write;
    logic [20:0] m_access_address;
    logic [15:0] m_access_data;
    logic        m_done_res;
    logic        m_failed;
    logic        m_last;

    logic        typed_on         = 1'b0;
    result_t     typed_exp        = '0;

    pend_t       pend_q           = PEND_NONE;
    logic [20:0] poll_addr_q      = '0;
    logic [21:0] words_left_q     = '0;
    logic [20:0] next_addr_q      = '0;
    logic        aborted_q        = 1'b0;

    result_t     step_accesses [4];
    int          step_count;
    result_t     awaited_results [$];

    int unsigned cycle_count      = 0;
    int unsigned mismatches       = 0;
    int unsigned idle_pct         = 0;
    int unsigned stall_pct        = 0;

    flash_command_sequencer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_block_number   (s_block_number),
        .s_word_address   (s_word_address),
        .s_run_words      (s_run_words),
        .s_write_data     (s_write_data),
        .s_read_data      (s_read_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_access_valid   (m_access_valid),
        .m_access_write   (m_access_write),
        .m_access_address (m_access_address),
        .m_access_data    (m_access_data),
        .m_done_res       (m_done_res),
        .m_failed         (m_failed),
        .m_last           (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void emit(input logic av, input logic wr, input logic [20:0] addr,
                                 input logic [15:0] data, input logic dn, input logic fl);
        result_t r;
        r.access_valid   = av;
        r.access_write   = av ? wr : 1'b0;
        r.access_address = av ? addr : '0;
        r.access_data    = (av && wr) ? data : '0;
        r.done_res       = dn;
        r.failed         = fl;
        r.last           = 1'b0;
        step_accesses[step_count] = r;
        step_count++;
    endfunction

    function automatic void sequence_flash(input request_t r);
        int unsigned offset;
        int unsigned room;
        logic        issue;
        step_count = 0;
        issue = 1'b0;
        if (r.op == OP_STATUS) begin
            if (pend_q == PEND_NONE) begin
                emit(0, 0, '0, '0, 1, 1);
            end else if (pend_q == PEND_UNLOCK) begin
                pend_q = PEND_NONE;
                emit(1, 1, '0, CMD_READ_ARRAY, 1, (r.rdata & PROT_LOCKED) != 0);
            end else if ((r.rdata & SR_READY) == 0) begin
                emit(1, 0, poll_addr_q, '0, 0, 0);
            end else if (pend_q == PEND_ERASE) begin
                pend_q = PEND_NONE;
                if ((r.rdata & SR_ERASE_ERR) != 0) begin
                    emit(1, 1, '0, CMD_CLR_STATUS, 0, 0);
                    emit(1, 1, '0, CMD_READ_ARRAY, 1, 1);
                end else begin
                    emit(1, 1, '0, CMD_READ_ARRAY, 1, 0);
                end
            end else begin
                pend_q = PEND_NONE;
                if (words_left_q != 0) words_left_q = words_left_q - 1'b1;
                if ((r.rdata & SR_PROG_ERR) != 0) begin
                    aborted_q = (words_left_q != 0);
                    emit(1, 1, '0, CMD_CLR_STATUS, 0, 0);
                    emit(1, 1, '0, CMD_READ_ARRAY, 1, 1);
                end else if (words_left_q == 0) begin
                    emit(1, 1, '0, CMD_READ_ARRAY, 1, 0);
                end else begin
                    emit(0, 0, '0, '0, 1, 0);
                end
            end
        end else if (pend_q != PEND_NONE) begin
            emit(0, 0, '0, '0, 1, 1);
        end else if (r.op == OP_PROGRAM) begin
            if (words_left_q != 0 && aborted_q) begin
                words_left_q = words_left_q - 1'b1;
                if (words_left_q == 0) aborted_q = 1'b0;
                emit(0, 0, '0, '0, 1, 1);
            end else begin
                issue = 1'b1;
                if (words_left_q == 0) begin
                    room = FLASH_SIZE - r.waddr;
                    if (r.waddr >= FLASH_SIZE || r.rwords > room) begin
                        emit(0, 0, '0, '0, 1, 1);
                        issue = 1'b0;
                    end else if (r.rwords == 0) begin
                        emit(1, 1, '0, CMD_READ_ARRAY, 1, 0);
                        issue = 1'b0;
                    end else begin
                        words_left_q = r.rwords;
                        next_addr_q  = r.waddr;
                        aborted_q    = 1'b0;
                    end
                end
                if (issue) begin
                    emit(1, 1, '0, CMD_CLR_STATUS, 0, 0);
                    emit(1, 1, '0, CMD_PROGRAM, 0, 0);
                    emit(1, 1, next_addr_q, r.wdata, 0, 0);
                    emit(1, 0, next_addr_q, '0, 0, 0);
                    poll_addr_q = next_addr_q;
                    next_addr_q = next_addr_q + 1'b1;
                    pend_q = PEND_PROGRAM;
                end
            end
        end else if (words_left_q != 0 || r.blk >= NUM_BLOCKS) begin
            emit(0, 0, '0, '0, 1, 1);
        end else begin
            offset = (r.blk < 8) ? r.blk * 32'h1000 : (r.blk - 7) * 32'h8000;
            if (r.op == OP_UNLOCK) begin
                emit(1, 1, '0, CMD_LOCK_SETUP, 0, 0);
                emit(1, 1, offset[20:0], CMD_CONFIRM, 0, 0);
                emit(1, 1, '0, CMD_READ_ID, 0, 0);
                poll_addr_q = offset[20:0] + PROT_OFFSET;
                emit(1, 0, poll_addr_q, '0, 0, 0);
                pend_q = PEND_UNLOCK;
            end else begin
                emit(1, 1, '0, CMD_CLR_STATUS, 0, 0);
                emit(1, 1, '0, CMD_ERASE, 0, 0);
                emit(1, 1, offset[20:0], CMD_CONFIRM, 0, 0);
                emit(1, 0, '0, '0, 0, 0);
                poll_addr_q = '0;
                pend_q = PEND_ERASE;
            end
        end
        step_accesses[step_count-1].last = 1'b1;
    endfunction

    // Mostly whole flash sessions: a command followed by its status polls, with some noise.
    function automatic request_t pick_request();
        request_t    r;
        int unsigned roll;
        int unsigned count;
        r.op     = OP_STATUS;
        r.blk    = 7'($urandom);
        r.waddr  = 21'($urandom);
        r.rwords = 22'($urandom);
        r.wdata  = 16'($urandom);
        r.rdata  = 16'($urandom);
        roll = $urandom_range(99);
        if (pend_q != PEND_NONE) begin
            if (roll < 8) begin
                r.op = op_t'($urandom_range(2));
            end else begin
                r.rdata[7] = ($urandom_range(99) >= 35);
                if ($urandom_range(99) < 70) r.rdata = r.rdata & ~16'h003B;
            end
        end else if (words_left_q != 0) begin
            if (roll < 85) r.op = OP_PROGRAM;
            else if (roll < 95) r.op = op_t'($urandom_range(1));
        end else begin
            if (roll < 25) r.op = OP_UNLOCK;
            else if (roll < 48) r.op = OP_ERASE;
            else if (roll < 92) r.op = OP_PROGRAM;
            if ($urandom_range(99) >= 10) r.blk = 7'($urandom_range(NUM_BLOCKS - 1));
            if (r.op == OP_PROGRAM) begin
                roll = $urandom_range(99);
                if (roll < 6) begin
                    r.rwords = '0;
                end else if (roll < 16) begin
                    count = FLASH_SIZE - r.waddr + 1;
                    r.rwords = 22'($urandom_range(32'h3FFFFF, count));
                end else begin
                    count = $urandom_range(6, 1);
                    r.rwords = 22'(count);
                    if (roll < 24) r.waddr = 21'(FLASH_SIZE - count);
                    else r.waddr = 21'($urandom_range(FLASH_SIZE - count));
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic drive_request(input request_t r, input logic typed, input result_t exp);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= r.op;
        s_block_number <= r.blk;
        s_word_address <= r.waddr;
        s_run_words    <= r.rwords;
        s_write_data   <= r.wdata;
        s_read_data    <= r.rdata;
        typed_on       <= typed;
        typed_exp      <= exp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** flash_command_sequencer: FAILED **");
            $finish;
        end
    end

    always @(posedge aclk) begin : watch
        request_t seen;
        result_t  got;
        result_t  want;
        if (aresetn && s_valid && s_ready) begin
            seen = '{op_t'(s_operation), s_block_number, s_word_address, s_run_words,
                     s_write_data, s_read_data};
            sequence_flash(seen);
            if (typed_on) begin
                awaited_results.push_back(typed_exp);
            end else begin
                for (int i = 0; i < step_count; i++) awaited_results.push_back(step_accesses[i]);
            end
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_access_valid, m_access_write, m_access_address, m_access_data,
                    m_done_res, m_failed, m_last};
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = awaited_results.pop_front();
                if (got.access_valid !== want.access_valid)
                    report_mismatch($sformatf("access_valid %b, expected %b",
                                              got.access_valid, want.access_valid));
                if (got.access_write !== want.access_write)
                    report_mismatch($sformatf("access_write %b, expected %b",
                                              got.access_write, want.access_write));
                if (got.access_address !== want.access_address)
                    report_mismatch($sformatf("access_address %h, expected %h",
                                              got.access_address, want.access_address));
                if (got.access_data !== want.access_data)
                    report_mismatch($sformatf("access_data %h, expected %h",
                                              got.access_data, want.access_data));
                if (got.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %b, expected %b",
                                              got.done_res, want.done_res));
                if (got.failed !== want.failed)
                    report_mismatch($sformatf("failed %b, expected %b",
                                              got.failed, want.failed));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (DIRECTED[i]) drive_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].exp);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 62 : (phase == 3) ? 14 : 0;
            stall_pct = (phase == 2) ? 62 : (phase == 3) ? 14 : 0;
            repeat (100) drive_request(pick_request(), 1'b0, EXP_NONE);
        end
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** flash_command_sequencer: PASSED **");
        end else begin
            $display("** flash_command_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/fcs_pkg.sv
rtl/core/fcs_front.sv
rtl/core/fcs_queue.sv
rtl/core/fcs_back.sv
rtl/core/flash_command_sequencer.sv
rtl/core/fcs_checker.sv
bench/flash_command_sequencer_test.sv
